// ===== src/stream_find_replace_top_assert.svh =====
// ----------------------------------------------------------------------------
// stream_find_replace_top_assert.svh
// Assertion macros used by the checker file sfr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_TOP_ASSERT_SVH
`define STREAM_FIND_REPLACE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define SFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants for the stream find/replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CHAR_W    = 8;
    localparam int CNT_W     = 4;   // holds 0..8 pending bytes
    localparam int WORD_W    = 64;  // pattern and replacement words
    localparam int REP_MAX   = 8;
    localparam int IDX_W     = 3;   // replacement byte index
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES,
        CFG_PATTERN_LENGTH,
        CFG_REPLACEMENT_BYTES,
        CFG_REPLACEMENT_LENGTH
    } t_cfg_index;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    // controller -> cell row
    typedef struct packed {
        logic              append;
        logic              shift;
        logic [CNT_W-1:0]  count;
        logic [CHAR_W-1:0] char_in;
    } t_row_ctl;

    // cell row -> controller
    typedef struct packed {
        logic [CHAR_W-1:0] front;
        logic              prefix;       // live bytes match the pattern head
        logic              prefix_next;  // same, after dropping the front byte
    } t_row_stat;

endpackage

// ===== src/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell
// One pending-byte cell: holds a byte, loads, or takes its neighbor's byte.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  logic                      i_clk,
    input  sfr_pkg::t_cell_op         i_op,
    input  logic [sfr_pkg::CHAR_W-1:0] i_load_byte,
    input  logic [sfr_pkg::CHAR_W-1:0] i_next_byte,
    input  logic [sfr_pkg::CHAR_W-1:0] i_pat_here,
    input  logic [sfr_pkg::CHAR_W-1:0] i_pat_prev,
    output logic [sfr_pkg::CHAR_W-1:0] o_byte,
    output logic                      o_eq_here,
    output logic                      o_eq_prev
);
    import sfr_pkg::*;

    logic [CHAR_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD:  r_byte <= i_load_byte;
            CELL_SHIFT: r_byte <= i_next_byte;
            CELL_HOLD:  r_byte <= r_byte;
            default:    r_byte <= r_byte;
        endcase
    end

    assign o_byte    = r_byte;
    // compare against own pattern slot and the slot one to the left
    assign o_eq_here = (r_byte == i_pat_here);
    assign o_eq_prev = (r_byte == i_pat_prev);

endmodule

// ===== src/sfr_row.sv =====
// ----------------------------------------------------------------------------
// sfr_row
// Row of pending-byte cells shifting toward the front, with prefix checks.
// ----------------------------------------------------------------------------
module sfr_row #(
    parameter int CELLS = 8
) (
    input  logic                      i_clk,
    input  sfr_pkg::t_row_ctl         i_ctl,
    input  logic [sfr_pkg::WORD_W-1:0] i_pattern,
    output sfr_pkg::t_row_stat        o_stat
);
    import sfr_pkg::*;

    logic [CHAR_W-1:0] w_byte [CELLS];
    t_cell_op          w_op   [CELLS];
    logic [CELLS-1:0]  w_live;
    logic [CELLS-1:0]  w_eq_here;
    logic [CELLS-1:0]  w_eq_prev;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [CHAR_W-1:0] w_next;
        logic [CHAR_W-1:0] w_prev_pat;

        if (g == CELLS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_byte[g+1];
        end

        if (g == 0) begin : g_head
            assign w_prev_pat = '0;
        end else begin : g_body
            assign w_prev_pat = i_pattern[CHAR_W*(g-1) +: CHAR_W];
        end

        assign w_live[g] = (CNT_W'(g) < i_ctl.count);

        always_comb begin
            if (i_ctl.shift) begin
                w_op[g] = CELL_SHIFT;
            end else if (i_ctl.append && (i_ctl.count == CNT_W'(g))) begin
                w_op[g] = CELL_LOAD;
            end else begin
                w_op[g] = CELL_HOLD;
            end
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op[g]),
            .i_load_byte (i_ctl.char_in),
            .i_next_byte (w_next),
            .i_pat_here  (i_pattern[CHAR_W*g +: CHAR_W]),
            .i_pat_prev  (w_prev_pat),
            .o_byte      (w_byte[g]),
            .o_eq_here   (w_eq_here[g]),
            .o_eq_prev   (w_eq_prev[g])
        );
    end

    always_comb begin
        o_stat.front       = w_byte[0];
        o_stat.prefix      = 1'b1;
        o_stat.prefix_next = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            if (w_live[i] && !w_eq_here[i]) begin
                o_stat.prefix = 1'b0;
            end
        end
        // after a shift, cell i sits at i-1 and stays live iff i < count
        for (int i = 1; i < CELLS; i++) begin
            if (w_live[i] && !w_eq_prev[i]) begin
                o_stat.prefix_next = 1'b0;
            end
        end
    end

endmodule

// ===== src/stream_find_replace_top.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_top: find/replace over a byte stream, pending bytes in a cell row
// Empty pattern: bytes go straight to the output register; else via the cell row first.
// Input stalls outside the idle state and while the output register is blocked; a
// release, a match or a line end sends 0..8 output bytes before input is taken again.
// Reset: synchronous active-low; clears control, config and both counts, not output data.
// ----------------------------------------------------------------------------
module stream_find_replace_top #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input byte stream
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sfr_pkg::CHAR_W-1:0]    i_char_in,
    input  logic                          i_line_end,
    // output byte stream
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sfr_pkg::CHAR_W-1:0]    o_char_out,
    output logic                          o_run_last,
    output logic [sfr_pkg::TOTAL_W-1:0]   o_matches_total,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::WORD_W-1:0]    i_cfg_data
);
    import sfr_pkg::*;

    localparam logic [CNT_W-1:0] PAT_CAP = CNT_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0] REP_CAP = CNT_W'(REP_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPL
    } t_state;

    t_state                 r_state,      n_state;
    logic [WORD_W-1:0]      r_pat_bytes;
    logic [CNT_W-1:0]       r_pat_len;
    logic [WORD_W-1:0]      r_rep_bytes;
    logic [CNT_W-1:0]       r_rep_len;
    logic [CNT_W-1:0]       r_count,      n_count;
    logic                   r_flush,      n_flush;
    logic [IDX_W-1:0]       r_idx,        n_idx;
    logic [COUNT_WIDTH-1:0] r_matches,    n_matches;
    logic                   r_out_valid,  n_out_valid;
    logic [CHAR_W-1:0]      r_out_char,   n_out_char;
    logic                   r_out_last,   n_out_last;
    logic [TOTAL_W-1:0]     r_out_total,  n_out_total;

    logic [CNT_W-1:0]       w_plen;
    logic [CNT_W-1:0]       w_rlen;
    logic [TOTAL_W-1:0]     w_total;
    logic [CHAR_W-1:0]      w_rep_byte;
    logic                   w_rep_last;
    logic                   w_slot_free;
    logic                   w_accept;
    t_row_ctl               w_row_ctl;
    t_row_stat              w_row_stat;

    assign w_plen = (r_pat_len > PAT_CAP) ? PAT_CAP : r_pat_len;
    assign w_rlen = (r_rep_len > REP_CAP) ? REP_CAP : r_rep_len;

    if (COUNT_WIDTH > TOTAL_W) begin : g_total_sat
        assign w_total = (|r_matches[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                                              : r_matches[TOTAL_W-1:0];
    end else begin : g_total_ext
        assign w_total = TOTAL_W'(r_matches);
    end

    assign w_rep_byte = r_rep_bytes[{r_idx, 3'b000} +: CHAR_W];
    assign w_rep_last = ((CNT_W'(r_idx) + CNT_W'(1)) == w_rlen);

    // output register is free, or its byte leaves this cycle
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !w_slot_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    sfr_row #(
        .CELLS (MAX_PATTERN)
    ) u_row (
        .i_clk     (i_clk),
        .i_ctl     (w_row_ctl),
        .i_pattern (r_pat_bytes),
        .o_stat    (w_row_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_flush     = r_flush;
        n_idx       = r_idx;
        n_matches   = r_matches;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_total = r_out_total;

        w_row_ctl.append  = 1'b0;
        w_row_ctl.shift   = 1'b0;
        w_row_ctl.count   = r_count;
        w_row_ctl.char_in = i_char_in;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_plen == '0) begin
                        n_out_valid = 1'b1;
                        n_out_char  = i_char_in;
                        n_out_last  = 1'b1;
                        n_out_total = w_total;
                    end else begin
                        w_row_ctl.append = 1'b1;
                        n_count          = r_count + CNT_W'(1);
                        n_flush          = i_line_end;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if ((r_count == w_plen) && w_row_stat.prefix) begin
                    // full match: drop pending, count it, send the replacement
                    n_count = '0;
                    if (r_matches != {COUNT_WIDTH{1'b1}}) begin
                        n_matches = r_matches + COUNT_WIDTH'(1);
                    end
                    n_idx   = '0;
                    n_state = (w_rlen == '0) ? ST_IDLE : ST_REPL;
                end else if (r_flush) begin
                    // line end: every pending byte goes out in order
                    n_state = ST_DRAIN;
                end else if (w_row_stat.prefix) begin
                    n_state = ST_IDLE;
                end else if (w_slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out_char      = w_row_stat.front;
                    n_out_last      = w_row_stat.prefix_next;
                    n_out_total     = w_total;
                    w_row_ctl.shift = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                    if (w_row_stat.prefix_next) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out_char      = w_row_stat.front;
                    n_out_last      = (r_count == CNT_W'(1));
                    n_out_total     = w_total;
                    w_row_ctl.shift = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_rep_byte;
                    n_out_last  = w_rep_last;
                    n_out_total = w_total;
                    n_idx       = r_idx + IDX_W'(1);
                    if (w_rep_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new pattern discards whatever is pending
        if (i_cfg_valid && o_cfg_ready &&
            ((t_cfg_index'(i_cfg_index) == CFG_PATTERN_BYTES) ||
             (t_cfg_index'(i_cfg_index) == CFG_PATTERN_LENGTH))) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_flush     <= 1'b0;
            r_idx       <= '0;
            r_matches   <= '0;
            r_out_valid <= 1'b0;
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_flush     <= n_flush;
            r_idx       <= n_idx;
            r_matches   <= n_matches;
            r_out_valid <= n_out_valid;
            r_out_char  <= n_out_char;
            r_out_last  <= n_out_last;
            r_out_total <= n_out_total;
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PATTERN_BYTES: begin
                        r_pat_bytes <= i_cfg_data;
                    end
                    CFG_PATTERN_LENGTH: begin
                        r_pat_len <= i_cfg_data[CNT_W-1:0];
                    end
                    CFG_REPLACEMENT_BYTES: begin
                        r_rep_bytes <= i_cfg_data;
                    end
                    CFG_REPLACEMENT_LENGTH: begin
                        r_rep_len <= i_cfg_data[CNT_W-1:0];
                    end
                    default: begin
                        r_rep_len <= r_rep_len;
                    end
                endcase
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_char_out      = r_out_char;
    assign o_run_last      = r_out_last;
    assign o_matches_total = r_out_total;

endmodule

// ===== src/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for stream_find_replace_top, attached by bind.
// ----------------------------------------------------------------------------
`include "stream_find_replace_top_assert.svh"

module sfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sfr_pkg::CHAR_W-1:0]    o_char_out,
    input logic                          o_run_last,
    input logic [sfr_pkg::TOTAL_W-1:0]   o_matches_total
);
    import sfr_pkg::*;

    // a held output transfer keeps its payload
    `SFR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_char_out) && $stable(o_run_last) && $stable(o_matches_total), "output payload changed while stalled")

    // no new input while the output register is blocked
    `SFR_ASSERT_SAME(a_in_backpressure, o_out_valid && i_out_stall, o_in_stall, "input taken while output blocked")

    // the shown replacement count never goes down
    `SFR_ASSERT_NEXT(a_total_monotonic, o_out_valid, !o_out_valid || (o_matches_total >= $past(o_matches_total)), "match count decreased")

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);
